// ===== hdl/tpsa_pkg.sv =====
// Shared constants, pipeline control type and quarter-wave table builder for the three-phase DDS.
package tpsa_pkg;

	// default configuration
	localparam int TICK_RATE_HZ_DEF  = 25000;
	localparam int PHASE_BITS_DEF    = 32;
	localparam int LUT_ADDR_BITS_DEF = 10;

	// field widths
	localparam int FREQ_W      = 15;
	localparam int FCLAMP_W    = 14;
	localparam int SINE_W      = 16;
	localparam int LUT_W       = 15;
	localparam int PHASE_OUT_W = 32;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 80;

	// frequency limits in centihertz
	localparam int FREQ_MIN = 2000;
	localparam int FREQ_MAX = 10000;

	// sine amplitude
	localparam int SINE_PEAK = 32767;

	// Q30 constants for the table builder
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	// quarter-wave entry: round(32767 * sin(pi/2 * idx / 2^addr_bits)), Taylor series in Q30
	function automatic logic [LUT_W-1:0] qlut_entry(input int idx, input int addr_bits);
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] f;
		logic [63:0] s;
		logic [63:0] e;
		t  = (64'(idx) * HALF_PI_Q30) >> addr_bits;
		t2 = (t * t) >> 30;
		f  = Q30_ONE - t2 / 64'd110;
		f  = Q30_ONE - ((t2 * f) >> 30) / 64'd72;
		f  = Q30_ONE - ((t2 * f) >> 30) / 64'd42;
		f  = Q30_ONE - ((t2 * f) >> 30) / 64'd20;
		f  = Q30_ONE - ((t2 * f) >> 30) / 64'd6;
		s  = (t * f) >> 30;
		e  = (s * 64'(SINE_PEAK) + (64'd1 << 29)) >> 30;
		if (e > 64'(SINE_PEAK)) begin
			e = 64'(SINE_PEAK);
		end
		return e[LUT_W-1:0];
	endfunction

endpackage

// ===== hdl/three_phase_sine_phase_accumulator_core.sv =====
// Stages from input request accept to result valid: step, step sum, phase, table, out.
// Throughput: one request per cycle; the stages stall together only where no bubble is free.
// The phase step is a two-stage reciprocal multiply; the accumulator adds it one stage later.
// Reset clears all stage valid flags and the phase accumulator; data registers are not reset.
// The sine table is a quarter-wave ROM read at two addresses with registered output.
module three_phase_sine_phase_accumulator_core #(
	parameter int TICK_RATE_HZ  = tpsa_pkg::TICK_RATE_HZ_DEF,
	parameter int PHASE_BITS    = tpsa_pkg::PHASE_BITS_DEF,
	parameter int LUT_ADDR_BITS = tpsa_pkg::LUT_ADDR_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [tpsa_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [14:0] freq_centihz
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [tpsa_pkg::M_TDATA_W-1:0] m_axis_tdata   // sine_a, sine_b, sine_c, phase_now
);
	import tpsa_pkg::*;

	pipe_en_t                  en;
	logic                      v_s1;
	logic                      v_s2;
	logic                      v_s3;
	logic                      v_s4;
	logic                      v_s5;
	logic                      acc_adv;
	logic [PHASE_BITS-1:0]     phase_step;
	logic [PHASE_BITS-1:0]     acc_q;
	logic [PHASE_BITS-1:0]     phase_s3;
	logic [PHASE_BITS-1:0]     phase_s4;
	logic [PHASE_BITS-1:0]     phase_s5;
	logic signed [SINE_W-1:0]  sine_a_s4;
	logic signed [SINE_W-1:0]  sine_b_s4;
	logic signed [SINE_W:0]    c_wide;
	logic signed [SINE_W-1:0]  c_sat;
	logic signed [SINE_W-1:0]  sine_a_s5;
	logic signed [SINE_W-1:0]  sine_b_s5;
	logic signed [SINE_W-1:0]  sine_c_s5;

	// stall chain: a stage loads when it is empty or its successor moves
	assign en.s5 = !v_s5 || m_axis_tready;
	assign en.s4 = !v_s4 || en.s5;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;
	assign s_axis_tready = en.s1;
	assign acc_adv = en.s3 && v_s2;

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= s_axis_tvalid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
		end
	end

	// frequency to phase step
	tpsa_step #(
		.TICK_RATE_HZ(TICK_RATE_HZ),
		.PHASE_BITS  (PHASE_BITS)
	) u_step (
		.clk         (clk),
		.en          (en),
		.freq_centihz(s_axis_tdata[FREQ_W-1:0]),
		.step_s2     (phase_step)
	);

	// phase accumulator: emit current phase, then advance by this request's step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (acc_adv) begin
			acc_q <= acc_q + phase_step;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			phase_s3 <= acc_q;
		end
		if (en.s4) begin
			phase_s4 <= phase_s3;
		end
	end

	// two-phase sine lookup
	tpsa_sine #(
		.PHASE_BITS   (PHASE_BITS),
		.LUT_ADDR_BITS(LUT_ADDR_BITS)
	) u_sine (
		.clk      (clk),
		.en       (en),
		.phase_s3 (phase_s3),
		.sine_a_s4(sine_a_s4),
		.sine_b_s4(sine_b_s4)
	);

	// third phase: negated sum, saturated
	assign c_wide = -({sine_a_s4[SINE_W-1], sine_a_s4} + {sine_b_s4[SINE_W-1], sine_b_s4});

	always_comb begin
		priority if (c_wide > (SINE_W+1)'(SINE_PEAK)) begin
			c_sat = SINE_W'(SINE_PEAK);
		end else if (c_wide < -(SINE_W+1)'(SINE_PEAK)) begin
			c_sat = -SINE_W'(SINE_PEAK);
		end else begin
			c_sat = c_wide[SINE_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en.s5) begin
			sine_a_s5 <= sine_a_s4;
			sine_b_s5 <= sine_b_s4;
			sine_c_s5 <= c_sat;
			phase_s5  <= phase_s4;
		end
	end

	assign m_axis_tvalid = v_s5;
	assign m_axis_tdata  = {PHASE_OUT_W'(phase_s5), sine_c_s5, sine_b_s5, sine_a_s5};

`ifndef SYNTHESIS
	// input is refused only when every stage holds a request
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5))
		else $error("input stalled with a free stage");

	// accumulator moves by exactly the step it was handed
	a_acc_step: assert property (@(posedge clk) disable iff (!arst_n)
		$past(acc_adv) |-> (acc_q == $past(acc_q + phase_step)))
		else $error("phase accumulator advanced by wrong amount");

	// the three phases balance unless the third one clipped
	a_balance: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((18'(signed'(sine_a_s5)) + 18'(signed'(sine_b_s5))
			+ 18'(signed'(sine_c_s5)) == 18'd0)
			|| (sine_c_s5 == SINE_W'(SINE_PEAK)) || (sine_c_s5 == -SINE_W'(SINE_PEAK))))
		else $error("three-phase sum not zero");
`endif

endmodule

// ===== hdl/tpsa_step.sv =====
// Frequency clamp and phase step computation: round(f * 2^PHASE_BITS / (100 * tick rate)).
module tpsa_step #(
	parameter int TICK_RATE_HZ = tpsa_pkg::TICK_RATE_HZ_DEF,
	parameter int PHASE_BITS   = tpsa_pkg::PHASE_BITS_DEF
) (
	input  logic                        clk,
	input  tpsa_pkg::pipe_en_t          en,
	input  logic [tpsa_pkg::FREQ_W-1:0] freq_centihz,
	output logic [PHASE_BITS-1:0]       step_s2
);
	import tpsa_pkg::*;

	// divide by constant via ceiling reciprocal; FracW keeps total error below 1/Div
	localparam int Div = 100 * TICK_RATE_HZ;
	localparam int FracW = $clog2(FREQ_MAX + 1) + $clog2(Div) + 1;
	localparam logic [127:0] DivWide = 128'(Div);
	localparam logic [127:0] KFull =
		((128'd1 << (PHASE_BITS + FracW)) + DivWide - 128'd1) / DivWide;
	localparam logic [127:0] HFull =
		(((DivWide >> 1) << FracW) + DivWide - 128'd1) / DivWide;
	localparam int KW = PHASE_BITS + FracW - $clog2(Div) + 2;
	localparam int KLoW = (KW + 1) / 2;
	localparam int KHiW = KW - KLoW;
	localparam logic [KLoW-1:0] KLo = KFull[KLoW-1:0];
	localparam logic [KHiW-1:0] KHi = KFull[KW-1:KLoW];
	localparam int ProdLoW = FCLAMP_W + KLoW;
	localparam int ProdHiW = FCLAMP_W + KHiW;
	localparam int SumW = FracW + PHASE_BITS;

	logic [FCLAMP_W-1:0] f_clamp;
	logic [ProdLoW-1:0]  p_lo_s1;
	logic [ProdHiW-1:0]  p_hi_s1;
	logic [SumW-1:0]     step_sum;

	// clamp to 20..100 Hz
	always_comb begin
		priority if (freq_centihz < FREQ_W'(FREQ_MIN)) begin
			f_clamp = FCLAMP_W'(FREQ_MIN);
		end else if (freq_centihz > FREQ_W'(FREQ_MAX)) begin
			f_clamp = FCLAMP_W'(FREQ_MAX);
		end else begin
			f_clamp = freq_centihz[FCLAMP_W-1:0];
		end
	end

	// stage 1: two partial products of f times the reciprocal
	always_ff @(posedge clk) begin
		if (en.s1) begin
			p_lo_s1 <= ProdLoW'(f_clamp) * ProdLoW'(KLo);
			p_hi_s1 <= ProdHiW'(f_clamp) * ProdHiW'(KHi);
		end
	end

	// recombine, add rounding half, drop fraction
	assign step_sum = (SumW'(p_hi_s1) << KLoW) + SumW'(p_lo_s1) + SumW'(HFull);

	// stage 2: phase step
	always_ff @(posedge clk) begin
		if (en.s2) begin
			step_s2 <= step_sum[FracW +: PHASE_BITS];
		end
	end

endmodule

// ===== hdl/tpsa_sine.sv =====
// Quarter-wave sine lookup for phase and phase plus 240 degrees, registered table read.
module tpsa_sine #(
	parameter int PHASE_BITS    = tpsa_pkg::PHASE_BITS_DEF,
	parameter int LUT_ADDR_BITS = tpsa_pkg::LUT_ADDR_BITS_DEF
) (
	input  logic                               clk,
	input  tpsa_pkg::pipe_en_t                 en,
	input  logic [PHASE_BITS-1:0]              phase_s3,
	output logic signed [tpsa_pkg::SINE_W-1:0] sine_a_s4,
	output logic signed [tpsa_pkg::SINE_W-1:0] sine_b_s4
);
	import tpsa_pkg::*;

	localparam int Size  = 1 << LUT_ADDR_BITS;
	localparam int AddrW = LUT_ADDR_BITS + 1;
	localparam logic [PHASE_BITS-1:0] Off240 =
		PHASE_BITS'(((64'd2 << PHASE_BITS) + 64'd1) / 64'd3);

	logic [LUT_W-1:0]      rom [0:Size];
	logic [PHASE_BITS-1:0] phase_b;
	logic [AddrW-1:0]      addr_a;
	logic [AddrW-1:0]      addr_b;
	logic [LUT_W-1:0]      mag_a_s4;
	logic [LUT_W-1:0]      mag_b_s4;
	logic                  neg_a_s4;
	logic                  neg_b_s4;

	// table address: odd quadrants read mirrored
	function automatic logic [AddrW-1:0] lut_addr(input logic [PHASE_BITS-1:0] p);
		logic [AddrW-1:0] off;
		off = {1'b0, p[PHASE_BITS-3 -: LUT_ADDR_BITS]};
		return p[PHASE_BITS-2] ? (AddrW'(Size) - off) : off;
	endfunction

	// quarter-wave contents, fixed at elaboration
	for (genvar gi = 0; gi <= Size; gi++) begin : g_rom
		assign rom[gi] = qlut_entry(gi, LUT_ADDR_BITS);
	end

	assign phase_b = phase_s3 + Off240;
	assign addr_a  = lut_addr(phase_s3);
	assign addr_b  = lut_addr(phase_b);

	// stage 4: two registered table reads and sign bits
	always_ff @(posedge clk) begin
		if (en.s4) begin
			mag_a_s4 <= rom[addr_a];
			mag_b_s4 <= rom[addr_b];
			neg_a_s4 <= phase_s3[PHASE_BITS-1];
			neg_b_s4 <= phase_b[PHASE_BITS-1];
		end
	end

	// lower half-turn negates
	assign sine_a_s4 = neg_a_s4 ? -$signed({1'b0, mag_a_s4}) : $signed({1'b0, mag_a_s4});
	assign sine_b_s4 = neg_b_s4 ? -$signed({1'b0, mag_b_s4}) : $signed({1'b0, mag_b_s4});

endmodule

// ===== tb/sv/three_phase_sine_phase_accumulator_core_tb.sv =====
// Self-checking testbench for the three-phase sine phase accumulator core.
`timescale 1ns / 1ps

module three_phase_sine_phase_accumulator_core_tb;

	localparam int TICK_HZ   = tpsa_pkg::TICK_RATE_HZ_DEF;
	localparam int PH_W      = tpsa_pkg::PHASE_BITS_DEF;
	localparam int ADDR_W    = tpsa_pkg::LUT_ADDR_BITS_DEF;
	localparam int QTR_SIZE  = 1 << ADDR_W;
	localparam int RESET_CHZ = 5000;
	localparam int RAND_ITEMS = 500;
	localparam int TAIL_ITEMS = 60;
	localparam logic [63:0] TICK_DIV  = 64'd100 * 64'(TICK_HZ);
	localparam logic [63:0] OFFSET_240 = ((64'd2 << PH_W) + 64'd1) / 64'd3;

	// one tick's three sines plus the phase they were taken at
	typedef struct {
		logic [tpsa_pkg::SINE_W-1:0]      sine_a;
		logic [tpsa_pkg::SINE_W-1:0]      sine_b;
		logic [tpsa_pkg::SINE_W-1:0]      sine_c;
		logic [tpsa_pkg::PHASE_OUT_W-1:0] phase_now;
	} tick_sines_t;

	// predicts each tick's sines and checks them against what the core returns
	class dds_scoreboard;
		int            quarter_wave [0:QTR_SIZE];
		logic [PH_W-1:0] phase_acc;
		logic [PH_W-1:0] phase_step;
		tick_sines_t   sines_due [$];
		int            errors;

		function new();
			logic [63:0] t;
			logic [63:0] t2;
			logic [63:0] h;
			logic [63:0] s;
			logic [63:0] q;
			// quarter-wave table: Taylor sine to degree 11 in Q30, products truncated
			for (int i = 0; i <= QTR_SIZE; i++) begin
				t  = (64'(i) * tpsa_pkg::HALF_PI_Q30) >> ADDR_W;
				t2 = (t * t) >> 30;
				h  = tpsa_pkg::Q30_ONE - t2 / 64'd110;
				h  = tpsa_pkg::Q30_ONE - ((t2 * h) >> 30) / 64'd72;
				h  = tpsa_pkg::Q30_ONE - ((t2 * h) >> 30) / 64'd42;
				h  = tpsa_pkg::Q30_ONE - ((t2 * h) >> 30) / 64'd20;
				h  = tpsa_pkg::Q30_ONE - ((t2 * h) >> 30) / 64'd6;
				s  = (t * h) >> 30;
				q  = (s * 64'(tpsa_pkg::SINE_PEAK) + (64'd1 << 29)) >> 30;
				if (q > 64'(tpsa_pkg::SINE_PEAK)) begin
					q = 64'(tpsa_pkg::SINE_PEAK);
				end
				quarter_wave[i] = int'(q);
			end
			phase_acc  = '0;
			phase_step = step_of(RESET_CHZ);
			errors     = 0;
		endfunction

		// rounded phase increment per tick for a frequency in centihertz
		function logic [PH_W-1:0] step_of(int unsigned chz);
			logic [63:0] num;
			num = (64'(chz) << PH_W) + TICK_DIV / 64'd2;
			return PH_W'(num / TICK_DIV);
		endfunction

		// table lookup: top two index bits pick the quadrant
		function int sine_at(logic [PH_W-1:0] ph);
			logic [ADDR_W+1:0] idx;
			int                off;
			int                v;
			idx = ph[PH_W-1 -: ADDR_W+2];
			off = int'(idx[ADDR_W-1:0]);
			v   = idx[ADDR_W] ? quarter_wave[QTR_SIZE-off] : quarter_wave[off];
			return idx[ADDR_W+1] ? -v : v;
		endfunction

		function int pending();
			return sines_due.size();
		endfunction

		// accepted request: new step first, sines at the current phase, then advance
		function void note_request(logic [tpsa_pkg::FREQ_W-1:0] freq);
			int unsigned     chz;
			logic [PH_W-1:0] ph;
			logic [PH_W-1:0] ph_b;
			int              a;
			int              b;
			int              c;
			tick_sines_t     due;
			chz = 32'(freq);
			if (chz < tpsa_pkg::FREQ_MIN) begin
				chz = tpsa_pkg::FREQ_MIN;
			end
			if (chz > tpsa_pkg::FREQ_MAX) begin
				chz = tpsa_pkg::FREQ_MAX;
			end
			phase_step = step_of(chz);
			ph   = phase_acc;
			ph_b = ph + OFFSET_240[PH_W-1:0];
			a    = sine_at(ph);
			b    = sine_at(ph_b);
			c    = -(a + b);
			if (c > tpsa_pkg::SINE_PEAK) begin
				c = tpsa_pkg::SINE_PEAK;
			end
			if (c < -tpsa_pkg::SINE_PEAK) begin
				c = -tpsa_pkg::SINE_PEAK;
			end
			due.sine_a    = a[tpsa_pkg::SINE_W-1:0];
			due.sine_b    = b[tpsa_pkg::SINE_W-1:0];
			due.sine_c    = c[tpsa_pkg::SINE_W-1:0];
			due.phase_now = tpsa_pkg::PHASE_OUT_W'(ph);
			sines_due.push_back(due);
			phase_acc = ph + phase_step;
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		// compare one returned tick with the oldest prediction
		task check_result(logic [tpsa_pkg::M_TDATA_W-1:0] data);
			tick_sines_t due;
			if (sines_due.size() == 0) begin
				report($sformatf("result %h with no request outstanding", data));
			end else begin
				due = sines_due.pop_front();
				if (data[15:0] !== due.sine_a) begin
					report($sformatf("sine_a %h, want %h (phase %h)",
						data[15:0], due.sine_a, due.phase_now));
				end
				if (data[31:16] !== due.sine_b) begin
					report($sformatf("sine_b %h, want %h (phase %h)",
						data[31:16], due.sine_b, due.phase_now));
				end
				if (data[47:32] !== due.sine_c) begin
					report($sformatf("sine_c %h, want %h (phase %h)",
						data[47:32], due.sine_c, due.phase_now));
				end
				if (data[79:48] !== due.phase_now) begin
					report($sformatf("phase_now %h, want %h", data[79:48], due.phase_now));
				end
			end
		endtask
	endclass

	logic                               clk;
	logic                               arst_n;
	logic                               s_axis_tvalid;
	logic                               s_axis_tready;
	logic [tpsa_pkg::S_TDATA_W-1:0]     s_axis_tdata;  // [14:0] freq_centihz
	logic                               m_axis_tvalid;
	logic                               m_axis_tready;
	logic [tpsa_pkg::M_TDATA_W-1:0]     m_axis_tdata;  // sine_a, sine_b, sine_c, phase_now

	dds_scoreboard sb = new();
	bit            quiet_tail;

	three_phase_sine_phase_accumulator_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#2_000_000;
		$display("three_phase_sine_phase_accumulator_core_tb: FAIL");
		$finish;
	end

	// result sampling
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tdata);
		end
	end

	// receiver backpressure: random stall bursts, none in the tail
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet_tail && $urandom_range(0, 2) == 0) begin
				@(negedge clk);
				m_axis_tready = 1'b0;
				repeat ($urandom_range(0, 16)) @(negedge clk);
			end
			@(negedge clk);
			m_axis_tready = 1'b1;
			repeat ($urandom_range(0, 30)) @(negedge clk);
		end
	end

	// one request, with an optional idle gap in front
	task send_freq(input logic [tpsa_pkg::FREQ_W-1:0] freq, input bit may_idle);
		if (may_idle && !quiet_tail && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(0, 16)) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {1'b0, freq};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(freq);
	endtask

	// hold off the sender until every outstanding tick has come back
	task drain_results();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// mostly in-range frequencies, some clamped low/high, some anywhere in 15 bits
	function automatic logic [tpsa_pkg::FREQ_W-1:0] pick_freq();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60) begin
			return tpsa_pkg::FREQ_W'($urandom_range(tpsa_pkg::FREQ_MIN, tpsa_pkg::FREQ_MAX));
		end
		if (sel < 75) begin
			return tpsa_pkg::FREQ_W'($urandom_range(0, tpsa_pkg::FREQ_MIN - 1));
		end
		if (sel < 90) begin
			return tpsa_pkg::FREQ_W'($urandom_range(tpsa_pkg::FREQ_MAX + 1, 20000));
		end
		return tpsa_pkg::FREQ_W'($urandom_range(0, 32767));
	endfunction

	initial begin
		logic [tpsa_pkg::FREQ_W-1:0] run_freq;
		int                          run_len;
		int                          sent;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		quiet_tail    = 1'b0;
		arst_n        = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed: clamp edges, field extremes, alternating bit patterns
		send_freq(15'd0, 1'b0);
		send_freq(15'd1, 1'b0);
		send_freq(15'd1999, 1'b0);
		send_freq(15'd2000, 1'b0);
		send_freq(15'd2001, 1'b1);
		send_freq(15'd5000, 1'b0);
		send_freq(15'd9999, 1'b1);
		send_freq(15'd10000, 1'b0);
		send_freq(15'd10001, 1'b0);
		send_freq(15'd16384, 1'b0);
		send_freq(15'd20000, 1'b1);
		send_freq(15'h7fff, 1'b0);
		send_freq(15'h2aaa, 1'b0);
		send_freq(15'h5555, 1'b0);
		send_freq(15'd0, 1'b0);
		drain_results();

		// random: runs of one frequency so the phase sweeps, with stray values mixed in
		sent = 0;
		while (sent < RAND_ITEMS) begin
			run_freq = pick_freq();
			run_len  = $urandom_range(1, 24);
			for (int k = 0; k < run_len && sent < RAND_ITEMS; k++) begin
				if ($urandom_range(0, 4) == 0) begin
					send_freq(pick_freq(), 1'b1);
				end else begin
					send_freq(run_freq, 1'b1);
				end
				sent++;
				if (sent == RAND_ITEMS / 2) begin
					drain_results();
				end
				if (sent == RAND_ITEMS - TAIL_ITEMS) begin
					quiet_tail = 1'b1;
				end
			end
		end
		@(negedge clk);
		s_axis_tvalid = 1'b0;

		// wait out the pipeline, then a little longer for strays
		while (sb.pending() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("three_phase_sine_phase_accumulator_core_tb: PASS");
		end else begin
			$display("three_phase_sine_phase_accumulator_core_tb: FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/tpsa_pkg.sv
hdl/tpsa_step.sv
hdl/tpsa_sine.sv
hdl/three_phase_sine_phase_accumulator_core.sv
tb/sv/three_phase_sine_phase_accumulator_core_tb.sv
